// ----- rtl/core/line_pixel_stepper_unit_macros.svh -----
// ----------------------------------------------------------------------------
// line pixel stepper assertion macros
// shared property shorthands for the stepper rtl
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_STEPPER_UNIT_MACROS_SVH
`define LINE_PIXEL_STEPPER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define LPS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lps assertion failed");

// next-cycle implication, checked outside reset
`define LPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lps assertion failed");

`endif

// ----- rtl/core/lps_pkg.sv -----
// ----------------------------------------------------------------------------
// lps_pkg
// shared types and codes of the line pixel stepper
// ----------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // classification of one word as it travels from front to back
  typedef struct packed {
    logic is_load;
    logic dir_a;
    logic dir_b;
    logic fin;
  } lps_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/line_pixel_stepper_unit.sv -----
// ----------------------------------------------------------------------------
// line_pixel_stepper_unit
// bresenham line rasterizer, one pixel word per input word
// ----------------------------------------------------------------------------
// A load word (cmd 0) sets up a line and returns its start pixel; each step
// word (cmd 1) returns the next pixel toward the end point, with last set on
// the end pixel. A step with no line in flight returns a word with valid_res
// low and all other fields zero. Every input word gives exactly one output
// word, tagged with draw_color as written on the config port (write it only
// while the unit is idle). The unit takes one word per clock while in_stall is
// low; each input word passes the input stage, the two-entry queue and the
// output register in that order. The back end does the per-step error update
// and coordinate move combinationally, which sets the one-per-clock rate.
`default_nettype none

module line_pixel_stepper_unit #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [23:0]           cfg_wr_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  cmd,
  input  wire logic [COORD_BITS-1:0] start_a,
  input  wire logic [COORD_BITS-1:0] start_b,
  input  wire logic [COORD_BITS-1:0] end_a,
  input  wire logic [COORD_BITS-1:0] end_b,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       valid_res,
  output logic [COORD_BITS-1:0]      pos_a,
  output logic [COORD_BITS-1:0]      pos_b,
  output logic [23:0]                pixel_color,
  output logic                       last
);
  import lps_pkg::*;

  localparam int ITEM_W = 6 * COORD_BITS + $bits(lps_ctrl_t);

  logic              q_push;
  logic              q_full;
  logic [ITEM_W-1:0] q_wr_data;
  logic              q_pop;
  logic              q_not_empty;
  logic [ITEM_W-1:0] q_rd_data;

  lps_front #(
    .COORD_BITS (COORD_BITS),
    .ITEM_W     (ITEM_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .start_a  (start_a),
    .start_b  (start_b),
    .end_a    (end_a),
    .end_b    (end_b),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wr_data)
  );

  lps_queue #(
    .ITEM_W (ITEM_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wr_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_rd_data)
  );

  lps_back #(
    .COORD_BITS (COORD_BITS),
    .ITEM_W     (ITEM_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_not_empty),
    .q_data      (q_rd_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .valid_res   (valid_res),
    .pos_a       (pos_a),
    .pos_b       (pos_b),
    .pixel_color (pixel_color),
    .last        (last)
  );

endmodule

`default_nettype wire

// ----- rtl/core/lps_front.sv -----
// ----------------------------------------------------------------------------
// lps_front
// accepts input words, classifies them and precomputes line setup
// ----------------------------------------------------------------------------
`default_nettype none

module lps_front #(
  parameter int COORD_BITS = 12,
  parameter int ITEM_W     = 6 * COORD_BITS + $bits(lps_pkg::lps_ctrl_t)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  cmd,
  input  wire logic [COORD_BITS-1:0] start_a,
  input  wire logic [COORD_BITS-1:0] start_b,
  input  wire logic [COORD_BITS-1:0] end_a,
  input  wire logic [COORD_BITS-1:0] end_b,
  input  wire logic                  q_full,
  output logic                       q_push,
  output logic [ITEM_W-1:0]          q_data
);
  import lps_pkg::*;

  logic                  held;
  logic                  accept;
  lps_ctrl_t             ctrl_in;
  logic [COORD_BITS-1:0] delta_a_in;
  logic [COORD_BITS-1:0] delta_b_in;

  assign in_stall = held && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = held && !q_full;

  always_comb begin
    ctrl_in.is_load = (cmd == CMD_LOAD);
    ctrl_in.dir_a   = !(start_a < end_a);
    ctrl_in.dir_b   = !(start_b < end_b);
    ctrl_in.fin     = (start_a == end_a) && (start_b == end_b);
    delta_a_in      = ctrl_in.dir_a ? (start_a - end_a) : (end_a - start_a);
    delta_b_in      = ctrl_in.dir_b ? (start_b - end_b) : (end_b - start_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (!q_full) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_data <= {ctrl_in, start_a, start_b, end_a, end_b, delta_a_in, delta_b_in};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lps_queue.sv -----
// ----------------------------------------------------------------------------
// lps_queue
// two-entry fifo between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module lps_queue #(
  parameter int ITEM_W = 76
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [ITEM_W-1:0] push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   not_empty,
  output logic [ITEM_W-1:0]      pop_data
);

  logic [ITEM_W-1:0] slots [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lps_back.sv -----
// ----------------------------------------------------------------------------
// lps_back
// line state, bresenham step and registered pixel output
// ----------------------------------------------------------------------------
`default_nettype none
`include "line_pixel_stepper_unit_macros.svh"

module lps_back #(
  parameter int COORD_BITS = 12,
  parameter int ITEM_W     = 6 * COORD_BITS + $bits(lps_pkg::lps_ctrl_t)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [23:0]           cfg_wr_data,
  input  wire logic                  q_valid,
  input  wire logic [ITEM_W-1:0]     q_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       valid_res,
  output logic [COORD_BITS-1:0]      pos_a,
  output logic [COORD_BITS-1:0]      pos_b,
  output logic [23:0]                pixel_color,
  output logic                       last
);
  import lps_pkg::*;

  localparam int EW = COORD_BITS + 2;
  localparam logic [COORD_BITS-1:0] ONE = {{(COORD_BITS-1){1'b0}}, 1'b1};

  lps_ctrl_t             ctrl;
  logic [COORD_BITS-1:0] in_sa, in_sb, in_ea, in_eb, in_da, in_db;

  logic [23:0]           draw_color;
  logic                  active;
  logic [COORD_BITS-1:0] cur_a, cur_b, tgt_a, tgt_b, delta_a, delta_b;
  logic                  dir_a, dir_b;
  logic signed [EW-1:0]  err_acc;
  logic signed [EW-1:0]  diff_ab;

  logic signed [EW:0]    e2;
  logic                  step_a, step_b;
  logic signed [EW-1:0]  err_adj;
  logic [COORD_BITS-1:0] cur_a_next, cur_b_next;
  logic                  step_fin;
  logic signed [EW-1:0]  load_diff;

  assign {ctrl, in_sa, in_sb, in_ea, in_eb, in_da, in_db} = q_data;

  assign q_pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    e2        = {err_acc, 1'b0};
    step_a    = e2 > -$signed({3'b000, delta_b});
    step_b    = e2 < $signed({3'b000, delta_a});
    if (step_a && step_b) begin
      err_adj = diff_ab;
    end else if (step_a) begin
      err_adj = -$signed({2'b00, delta_b});
    end else if (step_b) begin
      err_adj = $signed({2'b00, delta_a});
    end else begin
      err_adj = '0;
    end
    cur_a_next = cur_a;
    if (step_a) begin
      cur_a_next = dir_a ? (cur_a - ONE) : (cur_a + ONE);
    end
    cur_b_next = cur_b;
    if (step_b) begin
      cur_b_next = dir_b ? (cur_b - ONE) : (cur_b + ONE);
    end
    step_fin  = (cur_a_next == tgt_a) && (cur_b_next == tgt_b);
    load_diff = $signed({2'b00, in_da}) - $signed({2'b00, in_db});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draw_color <= '0;
      active     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        draw_color <= cfg_wr_data;
      end
      if (q_pop) begin
        out_valid <= 1'b1;
        if (ctrl.is_load) begin
          active <= !ctrl.fin;
        end else if (active && step_fin) begin
          active <= 1'b0;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // line state and output word, no reset needed
  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (ctrl.is_load) begin
        cur_a       <= in_sa;
        cur_b       <= in_sb;
        tgt_a       <= in_ea;
        tgt_b       <= in_eb;
        delta_a     <= in_da;
        delta_b     <= in_db;
        dir_a       <= ctrl.dir_a;
        dir_b       <= ctrl.dir_b;
        err_acc     <= load_diff;
        diff_ab     <= load_diff;
        valid_res   <= 1'b1;
        pos_a       <= in_sa;
        pos_b       <= in_sb;
        pixel_color <= draw_color;
        last        <= ctrl.fin;
      end else if (active) begin
        cur_a       <= cur_a_next;
        cur_b       <= cur_b_next;
        err_acc     <= err_acc + err_adj;
        valid_res   <= 1'b1;
        pos_a       <= cur_a_next;
        pos_b       <= cur_b_next;
        pixel_color <= draw_color;
        last        <= step_fin;
      end else begin
        // step with no line in flight
        valid_res   <= 1'b0;
        pos_a       <= '0;
        pos_b       <= '0;
        pixel_color <= '0;
        last        <= 1'b0;
      end
    end
  end

  `LPS_ASSERT_NOW(a_last_is_pixel, clk, rst, out_valid && last, valid_res)
  `LPS_ASSERT_NOW(a_empty_word_zero, clk, rst, out_valid && !valid_res,
    pos_a == '0 && pos_b == '0 && pixel_color == '0 && !last)
  `LPS_ASSERT_NOW(a_active_off_end, clk, rst, active,
    !(cur_a == tgt_a && cur_b == tgt_b))
  `LPS_ASSERT_NEXT(a_point_load_idle, clk, rst, q_pop && ctrl.is_load && ctrl.fin,
    !active)

endmodule

`default_nettype wire

// ----- sim/line_pixel_stepper_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_pixel_stepper_unit_tb
// self-checking bench for the bresenham line stepper: a queue-fed driver
// pushes load and step words, a line tracer predicts each pixel word, and a
// monitor checks every output word in order under random stalls
// ----------------------------------------------------------------------------

module line_pixel_stepper_unit_tb;
  import lps_pkg::*;

  localparam int COORD_BITS = 12;
  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_LEN   = 300;
  localparam int MAX_REPORT = 10;

  typedef struct packed {
    logic                  cmd;
    logic [COORD_BITS-1:0] start_a;
    logic [COORD_BITS-1:0] start_b;
    logic [COORD_BITS-1:0] end_a;
    logic [COORD_BITS-1:0] end_b;
  } line_word_t;

  typedef struct packed {
    logic                  valid_res;
    logic [COORD_BITS-1:0] pos_a;
    logic [COORD_BITS-1:0] pos_b;
    logic [23:0]           color;
    logic                  last;
  } pixel_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [23:0]           cfg_wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  cmd = CMD_LOAD;
  logic [COORD_BITS-1:0] start_a = '0;
  logic [COORD_BITS-1:0] start_b = '0;
  logic [COORD_BITS-1:0] end_a = '0;
  logic [COORD_BITS-1:0] end_b = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  valid_res;
  logic [COORD_BITS-1:0] pos_a;
  logic [COORD_BITS-1:0] pos_b;
  logic [23:0]           pixel_color;
  logic                  last;

  line_pixel_stepper_unit #(.COORD_BITS(COORD_BITS)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .start_a     (start_a),
    .start_b     (start_b),
    .end_a       (end_a),
    .end_b       (end_b),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .valid_res   (valid_res),
    .pos_a       (pos_a),
    .pos_b       (pos_b),
    .pixel_color (pixel_color),
    .last        (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  line_word_t  word_q[$];
  pixel_word_t pixel_exp_q[$];
  line_word_t  tx_word;
  int          mismatch_cnt = 0;
  int          queued_words = 0;
  bit          quiet = 1'b0;
  int          hold_req_cnt = 0;
  int          hold_ack_cnt = 0;
  int          hold_left = 0;
  int          dead_cycles = 0;

  // tracer state, mirrors the line the block is walking
  logic [23:0]           draw_color_r = '0;
  logic [COORD_BITS-1:0] at_a = '0, at_b = '0, goal_a = '0, goal_b = '0;
  logic [COORD_BITS-1:0] span_a = '0, span_b = '0;
  logic                  neg_a = 1'b0, neg_b = 1'b0;
  logic signed [COORD_BITS+1:0] err_r = '0;
  logic                  drawing = 1'b0;

  function automatic pixel_word_t trace_pixel(input line_word_t w);
    pixel_word_t p;
    int          e2;
    int          err_n;
    logic        fin;
    p = '0;
    if (w.cmd == CMD_LOAD) begin
      at_a   = w.start_a;
      at_b   = w.start_b;
      goal_a = w.end_a;
      goal_b = w.end_b;
      neg_a  = !(w.start_a < w.end_a);
      neg_b  = !(w.start_b < w.end_b);
      span_a = neg_a ? w.start_a - w.end_a : w.end_a - w.start_a;
      span_b = neg_b ? w.start_b - w.end_b : w.end_b - w.start_b;
      err_n  = int'(span_a) - int'(span_b);
      err_r  = err_n[COORD_BITS+1:0];
      fin    = (w.start_a == w.end_a) && (w.start_b == w.end_b);
      drawing = !fin;
      p = '{1'b1, at_a, at_b, draw_color_r, fin};
    end else if (drawing) begin
      e2    = 2 * int'(err_r);
      err_n = int'(err_r);
      // both tests use the doubled error from before the step
      if (e2 > -int'(span_b)) begin
        err_n = err_n - int'(span_b);
        at_a  = neg_a ? at_a - 1'b1 : at_a + 1'b1;
      end
      if (e2 < int'(span_a)) begin
        err_n = err_n + int'(span_a);
        at_b  = neg_b ? at_b - 1'b1 : at_b + 1'b1;
      end
      err_r = err_n[COORD_BITS+1:0];
      fin   = (at_a == goal_a) && (at_b == goal_b);
      if (fin) drawing = 1'b0;
      p = '{1'b1, at_a, at_b, draw_color_r, fin};
    end
    return p;
  endfunction

  // driver: keeps valid and payload steady until the word is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) pixel_exp_q.push_back(trace_pixel(tx_word));
      if (!in_valid || !in_stall) begin
        if (word_q.size() != 0 && (quiet || $urandom_range(99) >= 6)) begin
          tx_word = word_q.pop_front();
          in_valid <= 1'b1;
          cmd      <= tx_word.cmd;
          start_a  <= tx_word.start_a;
          start_b  <= tx_word.start_b;
          end_a    <= tx_word.end_a;
          end_b    <= tx_word.end_b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each taken output word, drives out_stall
  always @(posedge clk) begin
    pixel_word_t got;
    pixel_word_t want;
    bit          stall_n;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{valid_res, pos_a, pos_b, pixel_color, last};
        if (pixel_exp_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORT)
            $display("unexpected word: valid_res=%0d a=%0d b=%0d color=%h last=%0d",
                     got.valid_res, got.pos_a, got.pos_b, got.color, got.last);
        end else begin
          want = pixel_exp_q.pop_front();
          if (got.valid_res !== want.valid_res || got.pos_a !== want.pos_a ||
              got.pos_b !== want.pos_b || got.color !== want.color ||
              got.last !== want.last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORT) begin
              $display("mismatch: exp valid_res=%0d a=%0d b=%0d color=%h last=%0d",
                       want.valid_res, want.pos_a, want.pos_b, want.color, want.last);
              $display("          got valid_res=%0d a=%0d b=%0d color=%h last=%0d",
                       got.valid_res, got.pos_a, got.pos_b, got.color, got.last);
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_n = 1'b1;
      end else if (hold_ack_cnt != hold_req_cnt) begin
        hold_ack_cnt = hold_req_cnt;
        hold_left    = HOLD_LEN;
        stall_n      = 1'b1;
      end else begin
        stall_n = !quiet && ($urandom_range(99) < 6);
      end
      out_stall <= stall_n;
    end
  end

  // watchdog on cycles where neither side moves a word
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        dead_cycles <= 0;
      end else if (dead_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        dead_cycles <= dead_cycles + 1;
      end
    end
  end

  function automatic logic [COORD_BITS-1:0] pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return COORD_MAX[COORD_BITS-1:0];
    r = $urandom_range(COORD_MAX);
    return r[COORD_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_near(input logic [COORD_BITS-1:0] v,
                                                      input int reach);
    int off;
    off = $urandom_range(reach);
    if ($urandom_range(1) == 1 && int'(v) + off <= COORD_MAX)
      return v + off[COORD_BITS-1:0];
    if (int'(v) >= off) return v - off[COORD_BITS-1:0];
    return v + off[COORD_BITS-1:0];
  endfunction

  task automatic add_load(input logic [COORD_BITS-1:0] sa, sb, ea, eb);
    word_q.push_back('{CMD_LOAD, sa, sb, ea, eb});
    queued_words++;
  endtask

  task automatic add_steps(input int n);
    for (int i = 0; i < n; i++) begin
      // coordinates are ignored on a step, so they carry noise
      word_q.push_back('{CMD_STEP, pick_coord(), pick_coord(), pick_coord(), pick_coord()});
      queued_words++;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (word_q.size() != 0 || in_valid || pixel_exp_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_color(input logic [23:0] c);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    draw_color_r = c;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  // mostly whole lines walked to the end, some cut short or stepped a random count, some point lines, some noise
  task automatic add_random_lines(input int n);
    logic [COORD_BITS-1:0] sa, sb, ea, eb;
    int                    r, len, da, db;
    int                    target;
    target = queued_words + n;
    while (queued_words < target) begin
      r  = $urandom_range(99);
      sa = pick_coord();
      sb = pick_coord();
      if (r < 85 && r >= 60 && r < 75) begin
        ea = pick_coord();
        eb = pick_coord();
      end else begin
        ea = pick_near(sa, ($urandom_range(9) == 0) ? 200 : 24);
        eb = pick_near(sb, ($urandom_range(9) == 0) ? 200 : 24);
      end
      da  = (sa > ea) ? int'(sa) - int'(ea) : int'(ea) - int'(sa);
      db  = (sb > eb) ? int'(sb) - int'(eb) : int'(eb) - int'(sb);
      len = (da > db) ? da : db;
      if (r < 60) begin
        add_load(sa, sb, ea, eb);
        add_steps(len + (($urandom_range(4) == 0) ? $urandom_range(1, 2) : 0));
      end else if (r < 75) begin
        add_load(sa, sb, ea, eb);
        add_steps($urandom_range(40));
      end else if (r < 85) begin
        add_load(sa, sb, ea, eb);
        add_steps((len > 0) ? $urandom_range(len - 1) : 0);
      end else if (r < 92) begin
        add_load(sa, sb, sa, sb);
        add_steps($urandom_range(2));
      end else begin
        if ($urandom_range(1) == 1) add_load(sa, sb, pick_coord(), pick_coord());
        else add_steps(1);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_color(24'h000000);
    add_steps(1);
    add_load(12'd0, 12'd0, 12'hFFF, 12'hFFF);
    add_steps(2);
    add_load(12'hFFF, 12'd0, 12'd0, 12'hFFF);
    add_steps(2);
    add_load(12'd7, 12'd9, 12'd7, 12'd9);
    add_steps(1);
    add_load(12'd100, 12'd50, 12'd103, 12'd51);
    add_steps(4);
    add_load(12'd20, 12'd30, 12'd20, 12'd26);
    add_steps(4);
    add_load(12'hFFF, 12'hFFF, 12'hFFA, 12'hFFF);
    add_steps(5);
    wait_drained();

    write_color(24'hA5C33C);
    add_random_lines(300);
    wait_drained();

    // long output hold-off while the sender keeps offering
    write_color(24'hFFFFFF);
    quiet = 1'b1;
    hold_req_cnt++;
    add_random_lines(300);
    wait_drained();
    quiet = 1'b0;

    write_color(24'h000000);
    add_random_lines(300);
    wait_drained();

    write_color(24'($urandom_range(24'hFFFFFF)));
    add_random_lines(300);
    wait_drained();

    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && pixel_exp_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/lps_pkg.sv
rtl/core/lps_front.sv
rtl/core/lps_queue.sv
rtl/core/lps_back.sv
rtl/core/line_pixel_stepper_unit.sv
sim/line_pixel_stepper_unit_tb.sv
